// File: hdl/amsc_pkg.sv
// Shared types and constants for the audio mood state classifier.
package amsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Slot bank period is 18000 ms = 16 * 1125.
    localparam int unsigned SLOT_PERIOD_MS = 18000;
    localparam int          SLOT_PRE_SHIFT = 4;
    localparam int          SLOT_X_W       = 32 - SLOT_PRE_SHIFT;
    localparam int          SLOT_RECIP_W   = 29;
    localparam int          SLOT_SHIFT     = 39;
    localparam logic [SLOT_RECIP_W-1:0] SLOT_RECIP = 29'd488671835;

    typedef enum logic [1:0] {
        MOOD_SILENCE = 2'd0,
        MOOD_DISORG  = 2'd1,
        MOOD_LOCKED  = 2'd2
    } mood_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_ENTER = 3'd0,
        CFG_SILENCE_EXIT  = 3'd1,
        CFG_TEMPO_ENTER   = 3'd2,
        CFG_BEAT_ENTER    = 3'd3,
        CFG_TEMPO_EXIT    = 3'd4,
        CFG_BEAT_EXIT     = 3'd5,
        CFG_HYSTERESIS    = 3'd6,
        CFG_MIN_DWELL     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] silence_enter_ms;
        logic [31:0] silence_exit_ms;
        logic [15:0] tempo_enter;
        logic [15:0] beat_enter;
        logic [15:0] tempo_exit;
        logic [15:0] beat_exit;
        logic [31:0] hysteresis_ms;
        logic [31:0] min_dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        is_silent;
        logic [15:0] tempo_conf;
        logic [15:0] beat_conf;
    } in_t;

    typedef struct packed {
        mood_t       mood;
        logic [3:0]  visual_slot;
        logic        visual_changed;
    } out_t;

endpackage

// File: hdl/amsc_cfg_regs.sv
// Configuration register file for the mood classifier.
module amsc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [amsc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [amsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output amsc_pkg::cfg_t                  cfg
);

    amsc_pkg::cfg_t cfg_reg;
    amsc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (amsc_pkg::cfg_idx_t'(cfg_addr))
                amsc_pkg::CFG_SILENCE_ENTER: cfg_next.silence_enter_ms = cfg_wdata;
                amsc_pkg::CFG_SILENCE_EXIT:  cfg_next.silence_exit_ms  = cfg_wdata;
                amsc_pkg::CFG_TEMPO_ENTER:   cfg_next.tempo_enter      = cfg_wdata[15:0];
                amsc_pkg::CFG_BEAT_ENTER:    cfg_next.beat_enter       = cfg_wdata[15:0];
                amsc_pkg::CFG_TEMPO_EXIT:    cfg_next.tempo_exit       = cfg_wdata[15:0];
                amsc_pkg::CFG_BEAT_EXIT:     cfg_next.beat_exit        = cfg_wdata[15:0];
                amsc_pkg::CFG_HYSTERESIS:    cfg_next.hysteresis_ms    = cfg_wdata;
                amsc_pkg::CFG_MIN_DWELL:     cfg_next.min_dwell_ms     = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_enter_ms <= 32'd2000;
            cfg_reg.silence_exit_ms  <= 32'd200;
            cfg_reg.tempo_enter      <= 16'd39321;
            cfg_reg.beat_enter       <= 16'd39321;
            cfg_reg.tempo_exit       <= 16'd26214;
            cfg_reg.beat_exit        <= 16'd26214;
            cfg_reg.hysteresis_ms    <= 32'd500;
            cfg_reg.min_dwell_ms     <= 32'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/amsc_slot_bank.sv
// Rotating bank position: (now_ms / 18000) mod 4 by reciprocal multiply.
module amsc_slot_bank (
    input  logic [31:0] now_ms,
    output logic [1:0]  bank
);

    logic [amsc_pkg::SLOT_X_W-1:0]                         x;
    logic [amsc_pkg::SLOT_X_W+amsc_pkg::SLOT_RECIP_W-1:0]  prod;

    // now/16 then exact divide by 1125 via ceil(2^39/1125)
    assign x    = now_ms[31:amsc_pkg::SLOT_PRE_SHIFT];
    assign prod = {{amsc_pkg::SLOT_RECIP_W{1'b0}}, x}
                * {{amsc_pkg::SLOT_X_W{1'b0}}, amsc_pkg::SLOT_RECIP};
    assign bank = prod[amsc_pkg::SLOT_SHIFT+1:amsc_pkg::SLOT_SHIFT];

endmodule

// File: hdl/amsc_mood_core.sv
// Mood state registers and per-tick decision logic.
module amsc_mood_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  amsc_pkg::in_t  item,
    input  amsc_pkg::cfg_t cfg,
    output amsc_pkg::out_t result
);

    amsc_pkg::mood_t cur_mood_reg,  cur_mood_next;
    amsc_pkg::mood_t cand_mood_reg, cand_mood_next;
    logic [31:0]     cand_since_reg, cand_since_next;
    logic [31:0]     entered_at_reg, entered_at_next;
    logic [31:0]     silent_since_reg, silent_since_next;
    logic [31:0]     sound_since_reg, sound_since_next;
    logic [3:0]      last_slot_reg, last_slot_next;

    logic [1:0]      bank;
    logic [31:0]     now;
    logic            silent;
    logic [31:0]     entered_eff;
    logic            released;
    logic            locked_enter;
    logic            locked_stay;
    amsc_pkg::mood_t instant;
    amsc_pkg::mood_t next_mood;
    logic [3:0]      slot;

    amsc_slot_bank u_bank (
        .now_ms (item.now_ms),
        .bank   (bank)
    );

    assign now    = item.now_ms;
    assign silent = item.is_silent;

    always_comb begin
        entered_eff = (entered_at_reg == 32'd0) ? now : entered_at_reg;

        if (silent) begin
            silent_since_next = (silent_since_reg == 32'd0) ? now : silent_since_reg;
            sound_since_next  = 32'd0;
        end else begin
            sound_since_next  = (sound_since_reg == 32'd0) ? now : sound_since_reg;
            silent_since_next = 32'd0;
        end

        released = !silent && (sound_since_next != 32'd0)
                && ((now - sound_since_next) >= cfg.silence_exit_ms);
        locked_enter = !silent && (item.tempo_conf >= cfg.tempo_enter)
                    && (item.beat_conf >= cfg.beat_enter);
        locked_stay  = (cur_mood_reg == amsc_pkg::MOOD_LOCKED)
                    && (item.tempo_conf >= cfg.tempo_exit)
                    && (item.beat_conf >= cfg.beat_exit);

        priority if (silent && (silent_since_next != 32'd0)
                     && ((now - silent_since_next) >= cfg.silence_enter_ms)) begin
            instant = amsc_pkg::MOOD_SILENCE;
        end else if ((cur_mood_reg == amsc_pkg::MOOD_SILENCE) && !released) begin
            instant = amsc_pkg::MOOD_SILENCE;
        end else if (locked_enter || locked_stay) begin
            instant = amsc_pkg::MOOD_LOCKED;
        end else if ((cur_mood_reg == amsc_pkg::MOOD_SILENCE) && silent) begin
            instant = amsc_pkg::MOOD_SILENCE;
        end else begin
            instant = amsc_pkg::MOOD_DISORG;
        end

        if (instant != cur_mood_reg) begin
            if (instant != cand_mood_reg) begin
                cand_mood_next  = instant;
                cand_since_next = now;
            end else begin
                cand_mood_next  = cand_mood_reg;
                cand_since_next = cand_since_reg;
            end
            if (((now - cand_since_next) >= cfg.hysteresis_ms)
                && ((now - entered_eff) >= cfg.min_dwell_ms)) begin
                next_mood = instant;
            end else begin
                next_mood = cur_mood_reg;
            end
        end else begin
            cand_mood_next  = cur_mood_reg;
            cand_since_next = now;
            next_mood       = cur_mood_reg;
        end

        cur_mood_next   = next_mood;
        entered_at_next = (next_mood != cur_mood_reg) ? now : entered_eff;

        slot           = {next_mood, bank};
        last_slot_next = slot;
    end

    assign result.mood           = next_mood;
    assign result.visual_slot    = slot;
    assign result.visual_changed = (slot != last_slot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mood_reg     <= amsc_pkg::MOOD_SILENCE;
            cand_mood_reg    <= amsc_pkg::MOOD_SILENCE;
            cand_since_reg   <= 32'd0;
            entered_at_reg   <= 32'd0;
            silent_since_reg <= 32'd0;
            sound_since_reg  <= 32'd0;
            last_slot_reg    <= 4'd0;
        end else if (advance) begin
            cur_mood_reg     <= cur_mood_next;
            cand_mood_reg    <= cand_mood_next;
            cand_since_reg   <= cand_since_next;
            entered_at_reg   <= entered_at_next;
            silent_since_reg <= silent_since_next;
            sound_since_reg  <= sound_since_next;
            last_slot_reg    <= last_slot_next;
        end
    end

endmodule

// File: hdl/audio_mood_state_classifier.sv
// Audio mood state classifier: top level with request and result registers.
//
// Input channel s_valid/s_ready/s_data carries one frame tick per request:
// timestamp in ms, silence flag, tempo and beat confidences (Q0.16).
// Result channel m_valid/m_ready/m_data returns one result per request:
// mood, visual slot and a slot-changed flag, in request order.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// write only while no request is in flight.
// Throughput: one request per cycle while m_ready is high. The mood state
// update, including the reciprocal multiply for the slot bank, sits between
// the request register and the result register.
// Reset (synchronous, aresetn low) empties both registers, restores register
// defaults and returns the mood state to silence with all timestamps unset.
// Receiver stall: the result holds; one further request is taken into the
// request register, after which s_ready drops until m_ready returns.
module audio_mood_state_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  amsc_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output amsc_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [amsc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [amsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    amsc_pkg::cfg_t cfg;
    amsc_pkg::out_t result;

    logic           in_valid_reg, in_valid_next;
    amsc_pkg::in_t  in_data_reg;
    logic           out_valid_reg, out_valid_next;
    amsc_pkg::out_t out_data_reg;
    logic           advance;

    amsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    amsc_mood_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: hdl/amsc_checker.sv
// Port-level checks for the mood classifier, bound to the top level.
module amsc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input amsc_pkg::out_t m_data
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_mood_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.mood == amsc_pkg::MOOD_SILENCE
                  || m_data.mood == amsc_pkg::MOOD_DISORG
                  || m_data.mood == amsc_pkg::MOOD_LOCKED))
        else $error("mood out of range");

    a_slot_mood: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.visual_slot[3:2] == m_data.mood))
        else $error("visual slot bank does not match mood");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // with no result pending, an accepted request yields a result through the request and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && m_ready |=> ##1 m_valid)
        else $error("result missing after request");

endmodule

bind audio_mood_state_classifier amsc_checker u_amsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
